/* src/hvfuv_pkg.sv */
// Shared constants, CORDIC arc table and rounding helper for the fisheye vertex block.
`default_nettype none
package hvfuv_pkg;

    localparam int QUARTER_TURN = 12868;
    localparam int HALF_TURN    = 25736;
    localparam int FULL_TURN    = 51472;

    localparam int CORDIC_STEPS = 16;
    localparam int XYW          = 34;   // CORDIC x/y width, Q1.30 plus headroom
    localparam int ZW           = 23;   // CORDIC angle width, Q.20
    localparam int ANGW         = 18;   // Q3.13 angle width with wrap headroom

    localparam logic signed [XYW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic [19:0] ARC_TAB [0:CORDIC_STEPS-1] = '{
        20'd823550, 20'd486170, 20'd256879, 20'd130396,
        20'd65451,  20'd32757,  20'd16383,  20'd8192,
        20'd4096,   20'd2048,   20'd1024,   20'd512,
        20'd256,    20'd128,    20'd64,     20'd32
    };

    localparam logic [1:0] REG_RING_COUNT    = 2'd0;
    localparam logic [1:0] REG_SEGMENT_COUNT = 2'd1;
    localparam logic [1:0] REG_LENS_APERTURE = 2'd2;

    localparam int DEF_MAX_RINGS    = 256;
    localparam int DEF_MAX_SEGMENTS = 256;

    // Round half up from Q.30 to Q.15 and clamp to the symmetric range.
    function automatic logic signed [15:0] rnd_sat15(input logic signed [47:0] v);
        logic signed [47:0] t;
        t = (v + 48'sd16384) >>> 15;
        if (t > 48'sd32767)
            return 16'sd32767;
        else if (t < -48'sd32767)
            return -16'sd32767;
        else
            return 16'(t);
    endfunction

endpackage
`default_nettype wire

/* src/hvfuv_div.sv */
// Pipelined restoring divider: one quotient bit per cell.
`default_nettype none
module hvfuv_div #(
    parameter int NW = 25,
    parameter int DW = 10,
    parameter int QW = 16,
    parameter int TW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [TW-1:0] in_tag,
    output logic               out_valid,
    output logic [QW-1:0]      quo,
    output logic [TW-1:0]      out_tag
);

    logic          valid_reg [1:QW];
    logic [DW-1:0] rem_reg   [1:QW];
    logic [QW-1:0] sh_reg    [1:QW];
    logic [DW-1:0] den_reg   [1:QW];
    logic [TW-1:0] tag_reg   [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_cell
        logic          v_s;
        logic [DW-1:0] rem_s;
        logic [QW-1:0] sh_s;
        logic [DW-1:0] den_s;
        logic [TW-1:0] tag_s;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] sh_next;

        if (k == 0) begin : g_head
            assign v_s   = in_valid;
            assign rem_s = DW'(num[NW-1:QW]);
            assign sh_s  = num[QW-1:0];
            assign den_s = den;
            assign tag_s = in_tag;
        end else begin : g_body
            assign v_s   = valid_reg[k];
            assign rem_s = rem_reg[k];
            assign sh_s  = sh_reg[k];
            assign den_s = den_reg[k];
            assign tag_s = tag_reg[k];
        end

        assign trial    = {rem_s, sh_s[QW-1]};
        assign ge       = trial >= {1'b0, den_s};
        assign rem_next = ge ? DW'(trial - {1'b0, den_s}) : DW'(trial);
        assign sh_next  = {sh_s[QW-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else if (en)
                valid_reg[k+1] <= v_s;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next;
                sh_reg[k+1]  <= sh_next;
                den_reg[k+1] <= den_s;
                tag_reg[k+1] <= tag_s;
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign quo       = sh_reg[QW];
    assign out_tag   = tag_reg[QW];

endmodule
`default_nettype wire

/* src/hvfuv_rot.sv */
// CORDIC rotation pipeline: Q3.13 angle in, Q1.15 cosine and sine out.
`default_nettype none
module hvfuv_rot #(
    parameter int TW = 1
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   en,
    input  wire logic                                   in_valid,
    input  wire logic signed [hvfuv_pkg::ANGW-1:0]      ang,
    input  wire logic [TW-1:0]                          in_tag,
    output logic                                        out_valid,
    output logic signed [15:0]                          cos_val,
    output logic signed [15:0]                          sin_val,
    output logic [TW-1:0]                               out_tag
);

    localparam int N   = hvfuv_pkg::CORDIC_STEPS;
    localparam int XYW = hvfuv_pkg::XYW;
    localparam int ZW  = hvfuv_pkg::ZW;
    localparam int AW  = hvfuv_pkg::ANGW;

    logic                  valid_reg [0:N];
    logic signed [XYW-1:0] x_reg     [0:N];
    logic signed [XYW-1:0] y_reg     [0:N];
    logic signed [ZW-1:0]  z_reg     [0:N];
    logic                  neg_reg   [0:N];
    logic [TW-1:0]         tag_reg   [0:N];

    logic                  out_valid_reg;
    logic signed [15:0]    cos_reg;
    logic signed [15:0]    sin_reg;
    logic [TW-1:0]         out_tag_reg;

    logic signed [AW-1:0]  a_wrap;
    logic signed [AW-1:0]  a_quad;
    logic                  neg_next;
    logic signed [15:0]    c_rnd;
    logic signed [15:0]    s_rnd;

    // Wrap into one turn, then fold the outer quadrants onto the inner ones.
    always_comb
    begin
        if (ang > AW'(hvfuv_pkg::HALF_TURN))
            a_wrap = AW'(ang - AW'(hvfuv_pkg::FULL_TURN));
        else if (ang < -AW'(hvfuv_pkg::HALF_TURN))
            a_wrap = AW'(ang + AW'(hvfuv_pkg::FULL_TURN));
        else
            a_wrap = ang;

        if (a_wrap > AW'(hvfuv_pkg::QUARTER_TURN))
        begin
            a_quad   = AW'(a_wrap - AW'(hvfuv_pkg::HALF_TURN));
            neg_next = 1'b1;
        end
        else if (a_wrap < -AW'(hvfuv_pkg::QUARTER_TURN))
        begin
            a_quad   = AW'(a_wrap + AW'(hvfuv_pkg::HALF_TURN));
            neg_next = 1'b1;
        end
        else
        begin
            a_quad   = a_wrap;
            neg_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= hvfuv_pkg::CORDIC_GAIN_Q30;
            y_reg[0]   <= '0;
            z_reg[0]   <= ZW'(a_quad) <<< 7;
            neg_reg[0] <= neg_next;
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        logic signed [ZW-1:0] arc;
        assign arc = ZW'(hvfuv_pkg::ARC_TAB[i]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else if (en)
                valid_reg[i+1] <= valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - arc;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + arc;
                end
                neg_reg[i+1] <= neg_reg[i];
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign c_rnd = hvfuv_pkg::rnd_sat15(48'(x_reg[N]));
    assign s_rnd = hvfuv_pkg::rnd_sat15(48'(y_reg[N]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= valid_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg     <= neg_reg[N] ? -c_rnd : c_rnd;
            sin_reg     <= neg_reg[N] ? -s_rnd : s_rnd;
            out_tag_reg <= tag_reg[N];
        end
    end

    assign out_valid = out_valid_reg;
    assign cos_val   = cos_reg;
    assign sin_val   = sin_reg;
    assign out_tag   = out_tag_reg;

endmodule
`default_nettype wire

/* src/hvfuv_vec.sv */
// CORDIC vectoring pipeline: atan2 of two Q1.15 values, Q3.13 angle out.
`default_nettype none
module hvfuv_vec #(
    parameter int TW = 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic signed [15:0]                yy,
    input  wire logic signed [15:0]                xx,
    input  wire logic [TW-1:0]                     in_tag,
    output logic                                   out_valid,
    output logic signed [hvfuv_pkg::ANGW-1:0]      ang,
    output logic [TW-1:0]                          out_tag
);

    localparam int N   = hvfuv_pkg::CORDIC_STEPS;
    localparam int XYW = hvfuv_pkg::XYW;
    localparam int ZW  = hvfuv_pkg::ZW;
    localparam int AW  = hvfuv_pkg::ANGW;

    logic                  valid_reg [0:N];
    logic signed [XYW-1:0] x_reg     [0:N];
    logic signed [XYW-1:0] y_reg     [0:N];
    logic signed [ZW-1:0]  z_reg     [0:N];
    logic signed [AW-1:0]  off_reg   [0:N];
    logic                  zero_reg  [0:N];
    logic [TW-1:0]         tag_reg   [0:N];

    logic                  out_valid_reg;
    logic signed [AW-1:0]  ang_reg;
    logic [TW-1:0]         out_tag_reg;

    logic                  x_neg;
    logic signed [16:0]    x_abs;
    logic signed [16:0]    y_adj;
    logic signed [AW-1:0]  off_next;
    logic signed [ZW-1:0]  z_rnd;

    // Mirror the left half plane and remember the half-turn offset.
    always_comb
    begin
        x_neg = xx < 0;
        x_abs = x_neg ? -17'(xx) : 17'(xx);
        y_adj = x_neg ? -17'(yy) : 17'(yy);
        if (!x_neg)
            off_next = '0;
        else if (yy >= 0)
            off_next = AW'(hvfuv_pkg::HALF_TURN);
        else
            off_next = -AW'(hvfuv_pkg::HALF_TURN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= XYW'(x_abs) <<< 15;
            y_reg[0]    <= XYW'(y_adj) <<< 15;
            z_reg[0]    <= '0;
            off_reg[0]  <= off_next;
            zero_reg[0] <= (yy == 16'sd0) && (xx == 16'sd0);
            tag_reg[0]  <= in_tag;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        logic signed [ZW-1:0] arc;
        assign arc = ZW'(hvfuv_pkg::ARC_TAB[i]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else if (en)
                valid_reg[i+1] <= valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + arc;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - arc;
                end
                off_reg[i+1]  <= off_reg[i];
                zero_reg[i+1] <= zero_reg[i];
                tag_reg[i+1]  <= tag_reg[i];
            end
        end
    end

    assign z_rnd = (z_reg[N] + ZW'(64)) >>> 7;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= valid_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg     <= zero_reg[N] ? '0 : AW'(AW'(z_rnd) + off_reg[N]);
            out_tag_reg <= tag_reg[N];
        end
    end

    assign out_valid = out_valid_reg;
    assign ang       = ang_reg;
    assign out_tag   = out_tag_reg;

endmodule
`default_nettype wire

/* src/hemisphere_vertex_fisheye_uv.sv */
// Top level: hemisphere grid vertex and equidistant fisheye texture coordinate pipeline.
//
// Usage: each request on the s_ side names one grid point (ring, segment). One result per
// request leaves on the m_ side: the unit-hemisphere position and the fisheye u,v.
// The cfg_ port writes ring_count, segment_count and lens_aperture; write it only while
// the pipeline is empty.
// Pipeline: a request passes 102 register stages: one input stage, a 16-cell grid divider,
// an 18-stage CORDIC rotation, a product stage, an 18-stage CORDIC vectoring, a
// 29-cell radius divider, a second 18-stage rotation and the output register.
// Throughput: one request per cycle unless stalled; every cell of every chain advances
// together. Backpressure: when the output register holds a result that is not taken, the
// whole chain freezes and s_tready drops in the same cycle; nothing is lost or duplicated.
// Reset: clears all valid bits and loads ring_count 16, segment_count 32, aperture
// 25736. Payload registers are not reset.
`default_nettype none
module hemisphere_vertex_fisheye_uv #(
    parameter int MAX_RINGS    = hvfuv_pkg::DEF_MAX_RINGS,
    parameter int MAX_SEGMENTS = hvfuv_pkg::DEF_MAX_SEGMENTS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // ring_index[7:0], segment_index[15:8]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // pos_depth[14:0], pos_side[30:15], pos_up[46:31],
                                        // tex_u[62:47], tex_v[78:63], zero pad [79]
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    localparam int AW  = hvfuv_pkg::ANGW;
    localparam int GNW = 25;
    localparam int GDW = 10;
    localparam int GQW = 16;
    localparam int RNW = 30;
    localparam int RDW = 17;
    localparam int RQW = 29;

    logic [8:0]  ring_count_reg;
    logic [8:0]  segment_count_reg;
    logic [15:0] lens_aperture_reg;

    logic        en;

    logic        s0_valid_reg;
    logic [GNW-1:0] th_num_reg, ph_num_reg;
    logic [GDW-1:0] th_den_reg, ph_den_reg;
    logic [GNW-1:0] th_num_next, ph_num_next;
    logic [GDW-1:0] th_den_next, ph_den_next;
    logic [8:0]  n_ring, n_seg;

    logic           th_valid;
    logic [GQW-1:0] th_q, ph_q;
    logic [0:0]     th_tag;

    logic               tc_valid;
    logic signed [15:0] ct, st, cp, sp;
    logic [0:0]         tc_tag;

    logic               pc_valid_reg;
    logic [14:0]        depth_reg, scale_reg;
    logic signed [15:0] side_reg, up_reg;
    logic [14:0]        depth_next, scale_next;

    logic                 va_valid;
    logic signed [AW-1:0] ta_ang, ang_ab;
    logic [46:0]          va_tag;
    logic [0:0]           vb_tag;

    logic [13:0]    ta_pos;
    logic [15:0]    ap_eff;
    logic [RNW-1:0] r_num;
    logic [RDW-1:0] r_den;

    logic           r_valid;
    logic [RQW-1:0] r_q;
    logic [46+AW:0] r_tag;

    logic               rf_valid;
    logic signed [15:0] ca, sa;
    logic [46+RQW:0]    rf_tag;

    logic signed [47:0] pu, pv;
    logic signed [47:0] ru, rv;

    logic               out_valid_reg;
    logic [14:0]        o_depth_reg;
    logic signed [15:0] o_side_reg, o_up_reg, o_u_reg, o_v_reg;

    function automatic logic [GNW+GDW-1:0] grid_req(input logic [7:0]  idx,
                                                    input logic [8:0]  n,
                                                    input logic [16:0] twospan);
        logic [8:0] nm1;
        logic [8:0] ix;
        if (n < 9'd2)
            return {GNW'(0), GDW'(2)};
        nm1 = n - 9'd1;
        ix  = ({1'b0, idx} > nm1) ? nm1 : {1'b0, idx};
        return {GNW'(32'(ix) * 32'(twospan) + 32'(nm1)), {nm1, 1'b0}};
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767)
            return 16'sd32767;
        else if (v < -48'sd32768)
            return -16'sd32768;
        else
            return 16'(v);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_count_reg    <= 9'd16;
            segment_count_reg <= 9'd32;
            lens_aperture_reg <= 16'd25736;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                hvfuv_pkg::REG_RING_COUNT:    ring_count_reg    <= cfg_wdata[8:0];
                hvfuv_pkg::REG_SEGMENT_COUNT: segment_count_reg <= cfg_wdata[8:0];
                hvfuv_pkg::REG_LENS_APERTURE: lens_aperture_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance every stage unless a finished result is still waiting.
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_comb
    begin
        n_ring = (32'(ring_count_reg) > MAX_RINGS) ? 9'(MAX_RINGS) : ring_count_reg;
        n_seg  = (32'(segment_count_reg) > MAX_SEGMENTS) ? 9'(MAX_SEGMENTS)
                                                         : segment_count_reg;
        {th_num_next, th_den_next} = grid_req(s_tdata[7:0], n_ring,
                                              17'(2 * hvfuv_pkg::QUARTER_TURN));
        {ph_num_next, ph_den_next} = grid_req(s_tdata[15:8], n_seg,
                                              17'(2 * hvfuv_pkg::FULL_TURN));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th_num_reg <= th_num_next;
            th_den_reg <= th_den_next;
            ph_num_reg <= ph_num_next;
            ph_den_reg <= ph_den_next;
        end
    end

    hvfuv_div #(.NW(GNW), .DW(GDW), .QW(GQW), .TW(1)) u_div_theta (
        .clk, .rst_n, .en,
        .in_valid (s0_valid_reg), .num (th_num_reg), .den (th_den_reg), .in_tag (1'b0),
        .out_valid (th_valid), .quo (th_q), .out_tag (th_tag)
    );

    hvfuv_div #(.NW(GNW), .DW(GDW), .QW(GQW), .TW(1)) u_div_phi (
        .clk, .rst_n, .en,
        .in_valid (s0_valid_reg), .num (ph_num_reg), .den (ph_den_reg), .in_tag (1'b0),
        .out_valid (), .quo (ph_q), .out_tag ()
    );

    hvfuv_rot #(.TW(1)) u_rot_theta (
        .clk, .rst_n, .en,
        .in_valid (th_valid), .ang (AW'(th_q)), .in_tag (th_tag),
        .out_valid (tc_valid), .cos_val (ct), .sin_val (st), .out_tag (tc_tag)
    );

    hvfuv_rot #(.TW(1)) u_rot_phi (
        .clk, .rst_n, .en,
        .in_valid (th_valid), .ang (AW'(ph_q)), .in_tag (1'b0),
        .out_valid (), .cos_val (cp), .sin_val (sp), .out_tag ()
    );

    assign depth_next = (ct < 0) ? 15'd0 : ct[14:0];
    assign scale_next = (st < 0) ? 15'd0 : st[14:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_valid_reg <= 1'b0;
        else if (en)
            pc_valid_reg <= tc_valid && !tc_tag[0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            depth_reg <= depth_next;
            scale_reg <= scale_next;
            side_reg  <= hvfuv_pkg::rnd_sat15(48'(32'(sp) * 32'($signed({1'b0, scale_next}))));
            up_reg    <= hvfuv_pkg::rnd_sat15(48'(32'(cp) * 32'($signed({1'b0, scale_next}))));
        end
    end

    hvfuv_vec #(.TW(47)) u_vec_ring (
        .clk, .rst_n, .en,
        .in_valid (pc_valid_reg),
        .yy ($signed({1'b0, scale_reg})), .xx ($signed({1'b0, depth_reg})),
        .in_tag ({depth_reg, side_reg, up_reg}),
        .out_valid (va_valid), .ang (ta_ang), .out_tag (va_tag)
    );

    hvfuv_vec #(.TW(1)) u_vec_dir (
        .clk, .rst_n, .en,
        .in_valid (pc_valid_reg), .yy (up_reg), .xx (side_reg), .in_tag (1'b0),
        .out_valid (), .ang (ang_ab), .out_tag (vb_tag)
    );

    // r = round(ta * 2 * 8192 / aperture); zero aperture acts as one.
    always_comb
    begin
        ta_pos = (ta_ang < 0) ? 14'd0 : ta_ang[13:0];
        ap_eff = (lens_aperture_reg == 16'd0) ? 16'd1 : lens_aperture_reg;
        r_num  = RNW'({ta_pos, 15'd0}) + RNW'(ap_eff);
        r_den  = {ap_eff, 1'b0};
    end

    hvfuv_div #(.NW(RNW), .DW(RDW), .QW(RQW), .TW(47 + AW)) u_div_radius (
        .clk, .rst_n, .en,
        .in_valid (va_valid && !vb_tag[0]), .num (r_num), .den (r_den),
        .in_tag ({va_tag, ang_ab}),
        .out_valid (r_valid), .quo (r_q), .out_tag (r_tag)
    );

    hvfuv_rot #(.TW(47 + RQW)) u_rot_dir (
        .clk, .rst_n, .en,
        .in_valid (r_valid), .ang (r_tag[AW-1:0]), .in_tag ({r_tag[46+AW:AW], r_q}),
        .out_valid (rf_valid), .cos_val (ca), .sin_val (sa), .out_tag (rf_tag)
    );

    assign pu = $signed({19'd0, rf_tag[RQW-1:0]}) * 48'(ca);
    assign pv = $signed({19'd0, rf_tag[RQW-1:0]}) * 48'(sa);
    assign ru = (pu + 48'sd16384) >>> 15;
    assign rv = (pv + 48'sd16384) >>> 15;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= rf_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_depth_reg <= rf_tag[46+RQW:32+RQW];
            o_side_reg  <= rf_tag[31+RQW:16+RQW];
            o_up_reg    <= rf_tag[15+RQW:RQW];
            o_u_reg     <= sat16(ru);
            o_v_reg     <= sat16(rv);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, o_v_reg, o_u_reg, o_up_reg, o_side_reg, o_depth_reg};

    // Ring angle never passes the quarter turn.
    a_theta_range: assert property (@(posedge clk) disable iff (!rst_n)
        th_valid |-> (th_q <= GQW'(hvfuv_pkg::QUARTER_TURN)))
        else $error("ring angle beyond quarter turn");

    // Position components stay inside the symmetric Q1.15 range.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[30:15] != 16'h8000) && (m_tdata[46:31] != 16'h8000))
        else $error("position component hit -32768");

    // An empty output register never refuses a request.
    a_accept_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A result taken with nothing behind it leaves the output empty.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !rf_valid) |=> !m_tvalid)
        else $error("result repeated after hand-off");

endmodule
`default_nettype wire

/* dv/hemisphere_vertex_fisheye_uv_tb.sv */
// Testbench for the fisheye hemisphere vertex block: streams grid points and checks vertices.
`timescale 1ns / 1ps
module hemisphere_vertex_fisheye_uv_tb;

    localparam int LATENCY   = 102;
    localparam int WDOG_MAX  = 4000;
    localparam int N_RANDOM  = 1750;

    typedef struct packed {
        logic [7:0] seg;
        logic [7:0] ring;
    } grid_point_t;

    // last member sits in the lowest bits, matching m_tdata
    typedef struct packed {
        logic [15:0] tv;
        logic [15:0] tu;
        logic [15:0] up;
        logic [15:0] side;
        logic [14:0] depth;
    } vertex_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    hemisphere_vertex_fisheye_uv u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // predictor copy of the registers
    logic [8:0]  p_rings;
    logic [8:0]  p_segs;
    logic [15:0] p_aperture;

    grid_point_t pending_points[$];
    vertex_t     expected_vertices[$];
    int          mismatches;
    int          accepted_out;
    int          wdog;
    bit          hold_off;
    int          hold_len;

    localparam longint ARCS[16] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                                     8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void rotate(longint ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        bit flip;
        x = 652032874;
        y = 0;
        flip = 0;
        while (ang > hvfuv_pkg::HALF_TURN) ang -= hvfuv_pkg::FULL_TURN;
        while (ang < -hvfuv_pkg::HALF_TURN) ang += hvfuv_pkg::FULL_TURN;
        if (ang > hvfuv_pkg::QUARTER_TURN)
        begin
            ang -= hvfuv_pkg::HALF_TURN;
            flip = 1;
        end
        else if (ang < -hvfuv_pkg::QUARTER_TURN)
        begin
            ang += hvfuv_pkg::HALF_TURN;
            flip = 1;
        end
        z = ang * 128;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ARCS[i];
            end
            else
            begin
                x += dx; y -= dy; z += ARCS[i];
            end
        end
        x = clip((x + 16384) >>> 15, -32767, 32767);
        y = clip((y + 16384) >>> 15, -32767, 32767);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint vector_angle(longint yy, longint xx);
        longint x, y, z, dx, dy, off;
        off = 0;
        z = 0;
        if (yy == 0 && xx == 0)
            return 0;
        if (xx < 0)
        begin
            off = (yy >= 0) ? hvfuv_pkg::HALF_TURN : -hvfuv_pkg::HALF_TURN;
            xx = -xx;
            yy = -yy;
        end
        x = xx * 32768;
        y = yy * 32768;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += ARCS[i];
            end
            else
            begin
                x -= dx; y += dy; z -= ARCS[i];
            end
        end
        return ((z + 64) >>> 7) + off;
    endfunction

    function automatic longint grid_step(longint idx, longint cnt, longint span);
        longint n;
        n = cnt > 256 ? 256 : cnt;
        if (n < 2)
            return 0;
        if (idx > n - 1)
            idx = n - 1;
        return (idx * 2 * span + (n - 1)) / (2 * (n - 1));
    endfunction

    function automatic vertex_t project_point(grid_point_t p);
        longint ct, st, cp, sp, depth, scale, side, up, ta, ang, ca, sa, r, ap, u, v;
        vertex_t res;
        ap = (p_aperture == 0) ? 1 : p_aperture;
        rotate(grid_step(p.ring, p_rings, hvfuv_pkg::QUARTER_TURN), ct, st);
        rotate(grid_step(p.seg, p_segs, hvfuv_pkg::FULL_TURN), cp, sp);
        depth = clip(ct, 0, 32767);
        scale = clip(st, 0, 32767);
        side = clip((sp * scale + 16384) >>> 15, -32767, 32767);
        up = clip((cp * scale + 16384) >>> 15, -32767, 32767);
        ta = vector_angle(scale, depth);
        if (ta < 0)
            ta = 0;
        r = (ta * 32768 + ap) / (2 * ap);
        ang = vector_angle(up, side);
        rotate(ang, ca, sa);
        u = clip((r * ca + 16384) >>> 15, -32768, 32767);
        v = clip((r * sa + 16384) >>> 15, -32768, 32767);
        res.depth = depth[14:0];
        res.side = side[15:0];
        res.up = up[15:0];
        res.tu = u[15:0];
        res.tv = v[15:0];
        return res;
    endfunction

    // driver: predict on acceptance, then draw a gap
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_vertices.insert(expected_vertices.size(),
                                         project_point(grid_point_t'(s_tdata)));
                void'(pending_points.pop_front());
            end
            if (s_tvalid && !s_tready)
                ;   // hold the request
            else if (send_gap > 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_points.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_points[0];
                send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor: check results and pace m_tready
    int recv_gap;
    always @(posedge clk or negedge rst_n)
    begin
        vertex_t got, want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = vertex_t'(m_tdata[78:0]);
                accepted_out++;
                if (expected_vertices.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected vertex %h", m_tdata);
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("vertex %0d: exp d=%h s=%h z=%h u=%h v=%h",
                                accepted_out, want.depth, want.side, want.up,
                                want.tu, want.tv);
                            $display("vertex %0d: got d=%h s=%h z=%h u=%h v=%h",
                                accepted_out, got.depth, got.side, got.up,
                                got.tu, got.tv);
                        end
                    end
                end
            end
            if (hold_off)
                m_tready <= 1'b0;
            else if (recv_gap > 0)
            begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else if (m_tready && !(m_tvalid))
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready)
                    recv_gap <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 7);
            end
        end
    end

    // long receiver stall so the pipeline fills and backs up
    always @(posedge clk)
    begin
        if (hold_len > 0)
        begin
            hold_len <= hold_len - 1;
            if (hold_len == 1)
                hold_off <= 1'b0;
        end
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            wdog <= 0;
        else
        begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_MAX)
            begin
                $display("hemisphere_vertex_fisheye_uv: mismatch");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            hvfuv_pkg::REG_RING_COUNT:    p_rings = val[8:0];
            hvfuv_pkg::REG_SEGMENT_COUNT: p_segs = val[8:0];
            default:                      p_aperture = val;
        endcase
    endtask

    task automatic drain_pipeline();
        while (pending_points.size() != 0 || expected_vertices.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic add_point(input int r, input int s);
        grid_point_t p;
        p.ring = r[7:0];
        p.seg = s[7:0];
        pending_points.insert(pending_points.size(), p);
    endtask

    task automatic random_phase(input int n, input int rmax, input int smax);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                add_point($urandom_range(0, 255), $urandom_range(0, 255));
            else
                add_point($urandom_range(0, rmax), $urandom_range(0, smax));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = hvfuv_pkg::REG_RING_COUNT;
        cfg_wdata = '0;
        hold_off = 1'b0;
        hold_len = 0;
        mismatches = 0;
        accepted_out = 0;
        p_rings = 9'd16;
        p_segs = 9'd32;
        p_aperture = 16'd25736;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: poles, rims, seams, out-of-range indexes at reset settings
        add_point(0, 0);
        add_point(0, 17);
        add_point(15, 0);
        add_point(15, 31);
        add_point(15, 8);
        add_point(15, 16);
        add_point(15, 24);
        add_point(7, 5);
        add_point(255, 255);
        add_point(16, 32);
        add_point(170, 85);
        add_point(85, 170);
        drain_pipeline();

        // zero aperture, counts below two
        write_reg(hvfuv_pkg::REG_LENS_APERTURE, 16'd0);
        write_reg(hvfuv_pkg::REG_RING_COUNT, 16'd1);
        write_reg(hvfuv_pkg::REG_SEGMENT_COUNT, 16'd0);
        add_point(0, 0);
        add_point(200, 100);
        drain_pipeline();

        // counts above limit, smallest aperture
        write_reg(hvfuv_pkg::REG_RING_COUNT, 16'h01FF);
        write_reg(hvfuv_pkg::REG_SEGMENT_COUNT, 16'h01FF);
        write_reg(hvfuv_pkg::REG_LENS_APERTURE, 16'd1);
        add_point(255, 255);
        add_point(128, 64);
        add_point(1, 1);
        drain_pipeline();

        write_reg(hvfuv_pkg::REG_LENS_APERTURE, 16'd51472);
        write_reg(hvfuv_pkg::REG_RING_COUNT, 16'd2);
        write_reg(hvfuv_pkg::REG_SEGMENT_COUNT, 16'd2);
        add_point(1, 1);
        add_point(0, 1);
        add_point(1, 0);
        drain_pipeline();

        // random phases over several settings; hold off the receiver in the first
        write_reg(hvfuv_pkg::REG_RING_COUNT, 16'd256);
        write_reg(hvfuv_pkg::REG_SEGMENT_COUNT, 16'd256);
        write_reg(hvfuv_pkg::REG_LENS_APERTURE, 16'hFFFF);
        hold_off = 1'b1;
        hold_len = 400;
        random_phase(450, 255, 255);
        drain_pipeline();

        write_reg(hvfuv_pkg::REG_RING_COUNT, 16'd9);
        write_reg(hvfuv_pkg::REG_SEGMENT_COUNT, 16'd13);
        write_reg(hvfuv_pkg::REG_LENS_APERTURE, 16'($urandom_range(1, 51472)));
        random_phase(450, 8, 12);
        drain_pipeline();

        write_reg(hvfuv_pkg::REG_RING_COUNT, 16'($urandom_range(2, 256)));
        write_reg(hvfuv_pkg::REG_SEGMENT_COUNT, 16'($urandom_range(2, 256)));
        write_reg(hvfuv_pkg::REG_LENS_APERTURE, 16'($urandom_range(1, 2000)));
        random_phase(450, 255, 255);
        drain_pipeline();

        write_reg(hvfuv_pkg::REG_RING_COUNT, 16'($urandom));
        write_reg(hvfuv_pkg::REG_SEGMENT_COUNT, 16'($urandom));
        write_reg(hvfuv_pkg::REG_LENS_APERTURE, 16'($urandom));
        random_phase(400, 255, 255);
        drain_pipeline();

        if (mismatches == 0)
            $display("hemisphere_vertex_fisheye_uv: match");
        else
            $display("hemisphere_vertex_fisheye_uv: mismatch");
        $finish;
    end

endmodule
